@@ src/sbfd_pkg.sv @@
// shared constants and types for the sbus frame decoder
package sbfd_pkg;

  localparam int BYTE_W    = 8;
  localparam int WIN_LEN   = 25;
  localparam int NUM_PROP  = 16;
  localparam int NUM_RES   = 18;
  localparam int CH_W      = 11;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 16;
  localparam int FILL_W    = 5;
  localparam int PAY_BYTES = 22;
  localparam int FLAG_LOST = 2;

  // configuration register indexes
  localparam logic CFG_START_MARKER = 1'b0;
  localparam logic CFG_END_MARKER   = 1'b1;

  localparam logic [CH_W-1:0] DIGITAL_ON = 11'h7FF;

  // control for one result cell
  typedef struct packed {
    logic load;
    logic shift;
  } res_ctrl_t;

endpackage

@@ src/sbfd_byte_cell.sv @@
// one byte cell of the receive window shift line
module sbfd_byte_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [sbfd_pkg::BYTE_W-1:0] d_in,
  output logic [sbfd_pkg::BYTE_W-1:0] q
);
  import sbfd_pkg::*;

  logic [BYTE_W-1:0] byte_r;

  // take the neighbor's byte on every accepted beat
  always_ff @(posedge clk) begin
    if (en) begin
      byte_r <= d_in;
    end
  end

  assign q = byte_r;

endmodule

@@ src/sbfd_result_cell.sv @@
// one channel value cell of the result drain line
module sbfd_result_cell (
  input  logic                      clk,
  input  sbfd_pkg::res_ctrl_t       ctrl,
  input  logic [sbfd_pkg::CH_W-1:0] load_val,
  input  logic [sbfd_pkg::CH_W-1:0] shift_in,
  output logic [sbfd_pkg::CH_W-1:0] q
);
  import sbfd_pkg::*;

  logic [CH_W-1:0] val_r;
  logic [CH_W-1:0] val_nxt;

  // load a whole frame, or pass the neighbor's value toward the output
  always_comb begin
    val_nxt = val_r;
    if (ctrl.load) begin
      val_nxt = load_val;
    end else if (ctrl.shift) begin
      val_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

@@ src/sbus_frame_decoder_core.sv @@
// sbus frame decoder top level: byte window, frame match and result drain
//
//  channel  | ports                                  | beat
//  ---------+----------------------------------------+-----------------------------
//  input    | in_valid, in_ready, in_rx_byte         | one received byte
//  result   | out_valid, out_ready, out_channel_*,   | one channel of a frame,
//           | out_frame_lost, out_lost_frames,       | 18 beats per frame
//           | out_last                               |
//  config   | cfg_wr_en, cfg_index, cfg_wdata        | one register write
//
// a byte that completes no frame is always accepted, also while a frame drains.
// a byte that completes a frame loads 18 result cells; they leave one per cycle,
// so a matching byte waits until the previous frame's last beat is taken.
// output stalls hold the drain line; reset is synchronous and clears fill, lost-frame
// count and the drain state and sets the markers to 15 and 0; window bytes need no reset.
module sbus_frame_decoder_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sbfd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbfd_pkg::IDX_W-1:0]   out_channel_index,
  output logic [sbfd_pkg::CH_W-1:0]    out_channel_value,
  output logic                         out_frame_lost,
  output logic [sbfd_pkg::CNT_W-1:0]   out_lost_frames,
  output logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [sbfd_pkg::BYTE_W-1:0]  cfg_wdata
);
  import sbfd_pkg::*;

  logic [BYTE_W-1:0]      win_q [WIN_LEN];
  logic [BYTE_W-1:0]      start_marker_r;
  logic [BYTE_W-1:0]      end_marker_r;
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      fill_nxt;
  logic [CNT_W-1:0]       lost_cnt_r;
  logic [CNT_W-1:0]       lost_cnt_nxt;
  logic                   busy_r;
  logic                   busy_nxt;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       idx_nxt;
  logic                   lost_r;
  logic                   lost_nxt;
  logic                   in_beat;
  logic                   out_beat;
  logic                   last_beat;
  logic                   match_next;
  logic                   load;
  logic [8*PAY_BYTES-1:0] payload;
  logic [CH_W-1:0]        load_val [NUM_RES];
  logic [CH_W-1:0]        res_q [NUM_RES];
  res_ctrl_t              res_ctrl;

  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;
  assign last_beat = out_beat && out_last;

  // the incoming byte would close a frame
  assign match_next = (fill_r >= FILL_W'(WIN_LEN - 1)) && (win_q[1] == start_marker_r) &&
                      (in_rx_byte == end_marker_r);

  assign in_ready = !busy_r || !match_next || last_beat;
  assign load     = in_beat && match_next;

  // receive window shift line
  genvar gi;
  generate
    for (gi = 0; gi < WIN_LEN; gi++) begin : g_win
      if (gi == WIN_LEN - 1) begin : g_tail
        sbfd_byte_cell u_cell (
          .clk  (clk),
          .en   (in_beat),
          .d_in (in_rx_byte),
          .q    (win_q[gi])
        );
      end else begin : g_body
        sbfd_byte_cell u_cell (
          .clk  (clk),
          .en   (in_beat),
          .d_in (win_q[gi+1]),
          .q    (win_q[gi])
        );
      end
    end
  endgenerate

  // channel bytes of the window as it stands after this beat
  generate
    for (gi = 0; gi < PAY_BYTES; gi++) begin : g_pay
      assign payload[8*gi +: 8] = win_q[gi+2];
    end
  endgenerate

  // frame values: proportional channels, then the two digital flags
  generate
    for (gi = 0; gi < NUM_PROP; gi++) begin : g_prop
      assign load_val[gi] = payload[CH_W*gi +: CH_W];
    end
  endgenerate
  assign load_val[NUM_PROP]   = win_q[WIN_LEN-1][0] ? DIGITAL_ON : '0;
  assign load_val[NUM_PROP+1] = win_q[WIN_LEN-1][1] ? DIGITAL_ON : '0;

  // note: flag byte of the new window is the byte at position 23, now win_q[24]
  assign res_ctrl.load  = load;
  assign res_ctrl.shift = out_beat && !load;

  // result drain line
  generate
    for (gi = 0; gi < NUM_RES; gi++) begin : g_res
      if (gi == NUM_RES - 1) begin : g_tail
        sbfd_result_cell u_cell (
          .clk      (clk),
          .ctrl     (res_ctrl),
          .load_val (load_val[gi]),
          .shift_in ('0),
          .q        (res_q[gi])
        );
      end else begin : g_body
        sbfd_result_cell u_cell (
          .clk      (clk),
          .ctrl     (res_ctrl),
          .load_val (load_val[gi]),
          .shift_in (res_q[gi+1]),
          .q        (res_q[gi])
        );
      end
    end
  endgenerate

  // fill, lost count and drain control
  always_comb begin
    fill_nxt     = fill_r;
    lost_cnt_nxt = lost_cnt_r;
    busy_nxt     = busy_r;
    idx_nxt      = idx_r;
    lost_nxt     = lost_r;
    if (in_beat && (fill_r < FILL_W'(WIN_LEN))) begin
      fill_nxt = fill_r + 1'b1;
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      lost_nxt = win_q[WIN_LEN-1][FLAG_LOST];
      if (win_q[WIN_LEN-1][FLAG_LOST] && (lost_cnt_r != '1)) begin
        lost_cnt_nxt = lost_cnt_r + 1'b1;
      end
    end else if (last_beat) begin
      busy_nxt = 1'b0;
    end else if (out_beat) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r         <= '0;
      lost_cnt_r     <= '0;
      busy_r         <= 1'b0;
      idx_r          <= '0;
      lost_r         <= 1'b0;
      start_marker_r <= 8'd15;
      end_marker_r   <= 8'd0;
    end else begin
      fill_r     <= fill_nxt;
      lost_cnt_r <= lost_cnt_nxt;
      busy_r     <= busy_nxt;
      idx_r      <= idx_nxt;
      lost_r     <= lost_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_START_MARKER: start_marker_r <= cfg_wdata;
          CFG_END_MARKER:   end_marker_r   <= cfg_wdata;
          default:          ;
        endcase
      end
    end
  end

  // result beat
  assign out_valid         = busy_r;
  assign out_channel_index = idx_r;
  assign out_channel_value = res_q[0];
  assign out_frame_lost    = lost_r;
  assign out_lost_frames   = lost_cnt_r;
  assign out_last          = (idx_r == IDX_W'(NUM_RES - 1));

endmodule
